// File: hw/rtl/ssd_pkg.sv
// Shared constants and codes for the salted string decryptor.
// Used by ssd_gen and salted_string_decryptor; no dependencies.
package ssd_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_OK       = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_BAD      = 2'd3
	} status_t;

	// generator: x*mult+1, original variant also reduced mod 2^16-3
	localparam logic [15:0] GEN_MULT_ORIG = 16'd23311;
	localparam logic [15:0] GEN_MULT_LIC  = 16'd43313;
	localparam logic [16:0] GEN_MOD       = 17'd65533;

	// checksum covers at most this many bytes
	localparam int CHECK_LIMIT = 64;
	localparam int CNT_W       = $clog2(CHECK_LIMIT + 1);

	// register addresses (byte)
	localparam logic [2:0] ADDR_KEY     = 3'd0;
	localparam logic [2:0] ADDR_VARIANT = 3'd4;

endpackage

// File: hw/rtl/ssd_gen.sv
// Key and mask generator unit: one multiply, then in variant 0 modular fold steps.
// Depends on ssd_pkg for the multipliers and modulus.
module ssd_gen (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        variant,
	input  logic [31:0] operand,
	output logic        done,
	output logic [31:0] result
);
	import ssd_pkg::*;

	typedef enum logic [1:0] {
		G_IDLE,
		G_MUL,
		G_FOLD,
		G_FIX
	} gen_state_t;

	gen_state_t  state_q;
	logic [31:0] x_q;
	logic        v_q;
	logic [31:0] acc_q;
	logic [31:0] res_q;
	logic        done_q;

	logic [15:0] mult;
	logic [31:0] prod;
	logic [31:0] lin;
	logic [17:0] fold1;
	logic [16:0] fold2;
	logic [15:0] fixed;

	assign mult = v_q ? GEN_MULT_LIC : GEN_MULT_ORIG;
	assign prod = x_q * {16'b0, mult};
	assign lin  = prod + 32'd1;

	// 2^16 = 3 mod 65533: fold the high half in as hi*3
	assign fold1 = {2'b0, acc_q[31:16]} + {1'b0, acc_q[31:16], 1'b0} + {2'b0, acc_q[15:0]};
	assign fold2 = {15'b0, acc_q[17:16]} + {14'b0, acc_q[17:16], 1'b0} + {1'b0, acc_q[15:0]};
	assign fixed = (fold2 >= GEN_MOD) ? 16'(fold2 - GEN_MOD) : fold2[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
			v_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (start) begin
						x_q     <= operand;
						v_q     <= variant;
						state_q <= G_MUL;
					end
				end
				G_MUL: begin
					if (v_q) begin
						res_q   <= lin;
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else begin
						acc_q   <= lin;
						state_q <= G_FOLD;
					end
				end
				G_FOLD: begin
					acc_q   <= {14'b0, fold1};
					state_q <= G_FIX;
				end
				G_FIX: begin
					res_q   <= {16'b0, fixed};
					done_q  <= 1'b1;
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hw/rtl/salted_string_decryptor.sv
// Salted string decryptor top level: character decode, group sequencer, output register.
// Depends on ssd_pkg and ssd_gen (shared generator unit).
// A character inside a group is taken each cycle; a NUL or bad character outside a
// skipped message holds s_tready low until its status is sent; closing a group holds it
// low for generator runs (salt; check in variant 1 only; data: key, variant 1 mask, key)
// and three bytes sent. Reset clears control state; s_tready is high right after.
module salted_string_decryptor (
	input  logic        clk,
	input  logic        arst_n,
	// stream input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	// stream output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,   // last
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ssd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GEN,
		S_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_SALT,
		PH_CHECK,
		PH_DATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		GS_SALT,
		GS_CHECK,
		GS_KEY1,
		GS_MASK,
		GS_KEY2
	} gen_step_t;

	function automatic logic [31:0] rot32(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] d;
		d = {x, x} << r;
		return d[63:32];
	endfunction

	function automatic logic [23:0] unrot24(input logic [23:0] x, input logic [4:0] r);
		logic [4:0]  rr;
		logic [47:0] d;
		rr = (r >= 5'd24) ? (r - 5'd24) : r;
		d  = {x, x} >> rr;
		return d[23:0];
	endfunction

	seq_state_t       state_q;
	phase_t           phase_q;
	gen_step_t        step_q;
	logic [1:0]       cpos_q;
	logic [6:0]       hold_q [3];
	logic [23:0]      word_q;
	logic [31:0]      rk_q;
	logic [31:0]      mask_q;
	logic [15:0]      exp_sum_q;
	logic [7:0]       exp_par_q;
	logic [15:0]      sum_q;
	logic [7:0]       par_q;
	logic             stopped_q;
	logic [CNT_W-1:0] bc_q;
	logic [23:0]      key_q;
	logic             variant_q;
	logic             multi_q;
	logic [1:0]       idx_q;
	status_t          pstat_q;
	logic             gen_start_q;
	logic [31:0]      gen_x_q;
	logic             m_tvalid_q;
	logic [7:0]       ob_q;
	status_t          st_q;
	logic             last_q;

	logic        gen_done;
	logic [31:0] gen_res;
	logic        sym_ok;
	logic [6:0]  sixel;
	logic [24:0] grp_word;
	logic [23:0] chk_word;
	logic        sum_ok;
	logic        out_free;
	logic        emit_go;
	logic        cfg_wr;
	logic [7:0]  cur_byte;

	ssd_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gen_start_q),
		.variant (variant_q),
		.operand (gen_x_q),
		.done    (gen_done),
		.result  (gen_res)
	);

	always_comb begin
		sym_ok = (s_tdata >= 8'h30) && (s_tdata <= 8'h7a);
		if (s_tdata > 8'h60) begin
			sixel = 7'(s_tdata - 8'h3a);
		end else if (s_tdata > 8'h3d) begin
			sixel = 7'(s_tdata - 8'h34);
		end else begin
			sixel = 7'(s_tdata - 8'h30);
		end
	end

	// overlapping sixels are ORed, highest first
	assign grp_word = ({18'b0, sixel} << 18) | ({18'b0, hold_q[2]} << 12) |
	                  ({18'b0, hold_q[1]} << 6) | {18'b0, hold_q[0]};
	assign chk_word = grp_word[23:0] ^ mask_q[23:0];
	assign sum_ok   = (sum_q == exp_sum_q) && (par_q == exp_par_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = (state_q == S_EMIT) && out_free;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cur_byte = word_q[8*idx_q +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SALT;
			step_q      <= GS_SALT;
			cpos_q      <= 2'd0;
			hold_q[0]   <= 7'd0;
			hold_q[1]   <= 7'd0;
			hold_q[2]   <= 7'd0;
			rk_q        <= 32'd0;
			mask_q      <= 32'd0;
			exp_sum_q   <= 16'd0;
			exp_par_q   <= 8'd0;
			sum_q       <= 16'd0;
			par_q       <= 8'd0;
			stopped_q   <= 1'b0;
			bc_q        <= '0;
			key_q       <= 24'd0;
			variant_q   <= 1'b0;
			multi_q     <= 1'b0;
			idx_q       <= 2'd0;
			pstat_q     <= ST_BAD;
			gen_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			gen_start_q <= 1'b0;
			// hold the result until taken, load a new one when the register frees
			m_tvalid_q  <= emit_go || (m_tvalid_q && !m_tready);
			if (cfg_wr) begin
				if (paddr[2]) begin
					variant_q <= pwdata[0];
				end else begin
					key_q <= pwdata[23:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tdata == 8'd0) begin
							if (phase_q != PH_SKIP) begin
								if (phase_q == PH_DATA && cpos_q == 2'd0) begin
									pstat_q <= sum_ok ? ST_OK : ST_MISMATCH;
								end else begin
									pstat_q <= ST_BAD;
								end
								multi_q <= 1'b0;
								state_q <= S_EMIT;
							end
							phase_q <= PH_SALT;
							cpos_q  <= 2'd0;
						end else if (phase_q != PH_SKIP) begin
							if (!sym_ok) begin
								pstat_q <= ST_BAD;
								multi_q <= 1'b0;
								phase_q <= PH_SKIP;
								cpos_q  <= 2'd0;
								state_q <= S_EMIT;
							end else if (cpos_q != 2'd3) begin
								hold_q[cpos_q] <= sixel;
								cpos_q         <= cpos_q + 2'd1;
							end else begin
								cpos_q <= 2'd0;
								case (phase_q)
									PH_SALT: begin
										gen_x_q     <= {7'b0, grp_word};
										gen_start_q <= 1'b1;
										step_q      <= GS_SALT;
										state_q     <= S_GEN;
									end
									PH_CHECK: begin
										exp_sum_q <= chk_word[23:8];
										exp_par_q <= chk_word[7:0];
										phase_q   <= PH_DATA;
										if (variant_q) begin
											gen_x_q     <= mask_q;
											gen_start_q <= 1'b1;
											step_q      <= GS_CHECK;
											state_q     <= S_GEN;
										end
									end
									default: begin
										word_q      <= grp_word[23:0];
										gen_x_q     <= rk_q;
										gen_start_q <= 1'b1;
										step_q      <= GS_KEY1;
										state_q     <= S_GEN;
									end
								endcase
							end
						end
					end
				end
				S_GEN: begin
					if (gen_done) begin
						case (step_q)
							GS_SALT: begin
								mask_q    <= gen_res;
								rk_q      <= {8'b0, key_q};
								sum_q     <= 16'd0;
								par_q     <= 8'd0;
								stopped_q <= 1'b0;
								bc_q      <= '0;
								phase_q   <= PH_CHECK;
								state_q   <= S_IDLE;
							end
							GS_CHECK: begin
								mask_q  <= gen_res;
								state_q <= S_IDLE;
							end
							GS_KEY1: begin
								rk_q        <= gen_res;
								gen_start_q <= 1'b1;
								if (!variant_q) begin
									mask_q  <= rot32(mask_q, {1'b0, gen_res[3:0]});
									gen_x_q <= gen_res;
									step_q  <= GS_KEY2;
								end else begin
									gen_x_q <= rot32(mask_q, gen_res[4:0]);
									step_q  <= GS_MASK;
								end
							end
							GS_MASK: begin
								mask_q      <= gen_res;
								gen_x_q     <= rk_q;
								gen_start_q <= 1'b1;
								step_q      <= GS_KEY2;
							end
							default: begin
								rk_q    <= gen_res;
								word_q  <= unrot24(word_q ^ mask_q[23:0], gen_res[4:0]);
								multi_q <= 1'b1;
								idx_q   <= 2'd0;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (multi_q) begin
							ob_q   <= cur_byte;
							st_q   <= ST_DATA;
							last_q <= (idx_q == 2'd2);
							// stop summing at the first zero byte or at the limit
							if (!stopped_q) begin
								if (cur_byte == 8'd0 || bc_q >= CNT_W'(CHECK_LIMIT)) begin
									stopped_q <= 1'b1;
								end else begin
									sum_q <= sum_q + {8'b0, cur_byte};
									par_q <= par_q ^ cur_byte;
									bc_q  <= bc_q + 1'b1;
								end
							end
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd2) begin
								state_q <= S_IDLE;
							end
						end else begin
							ob_q    <= 8'd0;
							st_q    <= pstat_q;
							last_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ob_q;
	assign m_tuser  = st_q;
	assign m_tlast  = last_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr == ADDR_VARIANT) ? {31'b0, variant_q} :
	                  (paddr == ADDR_KEY) ? {8'b0, key_q} : 32'd0;

	// generator results arrive only while the sequencer waits for them
	a_gen_done_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		gen_done |-> (state_q == S_GEN))
		else $error("generator result outside of a generator step");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= CNT_W'(CHECK_LIMIT))
		else $error("checked byte count past limit");

	a_third_byte_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && multi_q && idx_q == 2'd2)
		|=> (m_tvalid && m_tlast && m_tuser == ST_DATA))
		else $error("third data byte not marked last");

	a_single_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && !multi_q)
		|=> (m_tvalid && m_tlast && m_tdata == 8'd0 && m_tuser != ST_DATA))
		else $error("status result malformed");

	a_no_gen_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> !gen_start_q)
		else $error("generator started during output");

endmodule

// File: test/ssd_checker.sv
// Checker for the salted string decryptor: watches the symbol, result and register ports,
// predicts every result from its own copy of the decoder state and compares them in order.
// Depends on ssd_pkg (status codes, register addresses).
module ssd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic [1:0]  m_tuser,   // [1:0] status
	input  logic        m_tlast,   // last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending
);
	import ssd_pkg::*;

	localparam logic [31:0] MULT_ORIG  = 32'd23311;
	localparam logic [31:0] MULT_LIC   = 32'd43313;
	localparam logic [31:0] MOD_ORIG   = 32'd65533;
	localparam int          SUM_LIMIT  = 64;
	localparam logic [7:0]  NO_SIXEL   = 8'hFF;
	localparam int          REPORT_MAX = 10;

	typedef enum logic [1:0] {PH_SALT, PH_CHECK, PH_DATA, PH_SKIP} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       is_last;
	} result_t;

	result_t     decrypted_q[$];
	result_t     got;
	result_t     want;
	logic [23:0] key_reg;
	logic        lic_variant;
	phase_t      phase;
	logic [1:0]  char_pos;
	logic [6:0]  sixel_hold[3];
	logic [31:0] running_key;
	logic [31:0] mask_word;
	logic [15:0] expected_sum;
	logic [15:0] running_sum;
	logic [7:0]  expected_parity;
	logic [7:0]  running_parity;
	logic        sum_stopped;
	int          bytes_checked;

	function automatic logic [31:0] gen_next(input logic [31:0] x);
		logic [31:0] t;
		t = x * (lic_variant ? MULT_LIC : MULT_ORIG) + 32'd1;
		return lic_variant ? t : t % MOD_ORIG;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
		return (r == 5'd0) ? x : ((x << r) | (x >> (6'd32 - r)));
	endfunction

	function automatic logic [23:0] rotr24(input logic [23:0] x, input logic [4:0] r);
		int n;
		n = r % 24;
		return (n == 0) ? x : ((x >> n) | (x << (24 - n)));
	endfunction

	function automatic logic [7:0] sixel_of(input logic [7:0] c);
		if (c < 8'h30 || c > 8'h7A)
			return NO_SIXEL;
		if (c > 8'h60)
			return c - 8'h3A;
		if (c > 8'h3D)
			return c - 8'h34;
		return c - 8'h30;
	endfunction

	function automatic void expect_result(input logic [7:0] b, input status_t st,
			input logic is_last);
		decrypted_q.push_back('{out_byte: b, status: st, is_last: is_last});
	endfunction

	task automatic decrypt_symbol(input logic [7:0] c);
		logic [7:0]  sx;
		logic [31:0] w;
		logic [23:0] plain;
		logic [7:0]  b;
		int          i;
		if (c == 8'h00) begin
			// end of message only counts at a group boundary of the data phase
			if (phase == PH_DATA && char_pos == 2'd0)
				expect_result(8'h00, (running_sum == expected_sum &&
					running_parity == expected_parity) ? ST_OK : ST_MISMATCH, 1'b1);
			else if (phase != PH_SKIP)
				expect_result(8'h00, ST_BAD, 1'b1);
			phase = PH_SALT;
			char_pos = 2'd0;
			return;
		end
		if (phase == PH_SKIP)
			return;
		sx = sixel_of(c);
		if (sx == NO_SIXEL) begin
			expect_result(8'h00, ST_BAD, 1'b1);
			phase = PH_SKIP;
			char_pos = 2'd0;
			return;
		end
		if (char_pos != 2'd3) begin
			sixel_hold[char_pos] = sx[6:0];
			char_pos++;
			return;
		end
		char_pos = 2'd0;
		// a sixel of 64 overlaps the next one up, so OR instead of concatenating
		w = {24'd0, sx};
		for (i = 2; i >= 0; i--)
			w = (w << 6) | {25'd0, sixel_hold[i]};
		case (phase)
			PH_SALT: begin
				mask_word = gen_next(w);
				running_key = {8'd0, key_reg};
				running_sum = '0;
				running_parity = '0;
				sum_stopped = 1'b0;
				bytes_checked = 0;
				phase = PH_CHECK;
			end
			PH_CHECK: begin
				w = w ^ mask_word;
				expected_sum = w[23:8];
				expected_parity = w[7:0];
				if (lic_variant)
					mask_word = gen_next(mask_word);
				phase = PH_DATA;
			end
			default: begin
				running_key = gen_next(running_key);
				if (lic_variant)
					mask_word = gen_next(rotl32(mask_word, running_key[4:0]));
				else
					mask_word = rotl32(mask_word, {1'b0, running_key[3:0]});
				running_key = gen_next(running_key);
				plain = rotr24(w[23:0] ^ mask_word[23:0], running_key[4:0]);
				for (i = 0; i < 3; i++) begin
					b = plain[8*i +: 8];
					if (!sum_stopped) begin
						if (b == 8'h00 || bytes_checked >= SUM_LIMIT) begin
							sum_stopped = 1'b1;
						end else begin
							running_sum = running_sum + {8'd0, b};
							running_parity = running_parity ^ b;
							bytes_checked++;
						end
					end
					expect_result(b, ST_DATA, i == 2);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypted_q.delete();
			key_reg = '0;
			lic_variant = 1'b0;
			phase = PH_SALT;
			char_pos = 2'd0;
			sixel_hold = '{default: '0};
			running_key = '0;
			mask_word = '0;
			expected_sum = '0;
			running_sum = '0;
			expected_parity = '0;
			running_parity = '0;
			sum_stopped = 1'b0;
			bytes_checked = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_KEY:     key_reg = pwdata[23:0];
					ADDR_VARIANT: lic_variant = pwdata[0];
					default:      ;
				endcase
			end
			if (s_tvalid && s_tready)
				decrypt_symbol(s_tdata);
			if (m_tvalid && m_tready) begin
				got = '{out_byte: m_tdata, status: status_t'(m_tuser), is_last: m_tlast};
				if (decrypted_q.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected result: byte %02h status %0d last %0b",
							got.out_byte, got.status, got.is_last);
					mismatches++;
				end else begin
					want = decrypted_q.pop_front();
					if (got != want) begin
						if (mismatches < REPORT_MAX)
							$display("mismatch: exp %02h/%0d/%0b got %02h/%0d/%0b",
								want.out_byte, want.status, want.is_last,
								got.out_byte, got.status, got.is_last);
						mismatches++;
					end
				end
			end
			pending = decrypted_q.size();
		end
	end

endmodule

// File: test/tb_salted_string_decryptor.sv
// Testbench top for the salted string decryptor: clock, reset, register writes, symbol
// stimulus and result back-pressure; prediction and comparison live in ssd_checker.
// Depends on ssd_pkg, salted_string_decryptor and ssd_checker.
module tb_salted_string_decryptor;
	import ssd_pkg::*;

	localparam int SYMBOL_TARGET = 360;
	localparam int SETTING_SPAN  = 50;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PLAN_LEN      = 6;

	typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_THIRD, READY_BURSTY}
		ready_mode_t;
	typedef enum int {MSG_CLEAN, MSG_BAD_CHAR, MSG_CUT, MSG_NOISE} msg_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] symbol
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] out_byte
	logic [1:0]  m_tuser;           // [1:0] status
	logic        m_tlast;           // last
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          pending;

	int          sent = 0;
	int          burst_left = 0;
	int          quiet = 0;
	int          stall_cnt = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	logic [23:0] cur_key = '0;
	logic        cur_lic = 1'b0;
	logic [7:0]  msg_q[$];
	logic [23:0] key_plan[PLAN_LEN];
	logic        variant_plan[PLAN_LEN];
	logic [7:0]  directed_syms[25] = '{
		8'h00, 8'hFF, 8'h41, 8'h00,
		8'h30, 8'h3D, 8'h3E, 8'h60,
		8'h61, 8'h7A, 8'h7A, 8'h2F, 8'h00,
		8'h7A, 8'h7A, 8'h7A, 8'h7A,
		8'h30, 8'h30, 8'h30, 8'h30,
		8'h7A, 8'h7A, 8'h31, 8'h00
	};

	salted_string_decryptor u_top (.*);
	ssd_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 0)
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
			READY_THIRD:  m_tready <= (stall_cnt % 3 == 0);
			default:      m_tready <= (stall_cnt % 16 < 11);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("[salted_string_decryptor] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] gen_step(input logic [31:0] x, input logic lic);
		logic [31:0] t;
		t = x * (lic ? 32'd43313 : 32'd23311) + 32'd1;
		return lic ? t : t % 32'd65533;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
		return (r == 5'd0) ? x : ((x << r) | (x >> (6'd32 - r)));
	endfunction

	function automatic logic [23:0] rotl24(input logic [23:0] x, input logic [4:0] r);
		int n;
		n = r % 24;
		return (n == 0) ? x : ((x << n) | (x >> (24 - n)));
	endfunction

	// pick among the overlapping character ranges where a sixel has two spellings
	function automatic logic [7:0] sixel_char(input logic [5:0] v);
		if (v >= 6'd10 && v <= 6'd13 && $urandom_range(0, 1) == 1)
			return 8'h34 + v;
		if (v >= 6'd39 && v <= 6'd44 && $urandom_range(0, 1) == 1)
			return 8'h3A + v;
		if (v <= 6'd13)
			return 8'h30 + v;
		if (v <= 6'd44)
			return 8'h34 + v;
		return 8'h3A + v;
	endfunction

	function automatic void encode_word(input logic [23:0] w);
		for (int i = 0; i < 4; i++)
			msg_q.push_back(sixel_char(w[6*i +: 6]));
	endfunction

	task automatic send_symbol(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		sent++;
	endtask

	// leave psel high: the caller drops it once after the last write
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// salt and check groups give no result but may still be in the generator
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [23:0] key, input logic lic);
		settle();
		write_reg(ADDR_KEY, {8'd0, key});
		write_reg(ADDR_VARIANT, {31'd0, lic});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_key = key;
		cur_lic = lic;
	endtask

	// data groups go first so the check group can carry their sum and parity
	task automatic build_message(input msg_kind_t kind);
		logic [31:0] salt_mask;
		logic [31:0] mask;
		logic [31:0] key;
		logic [23:0] salt;
		logic [23:0] plain;
		logic [23:0] check;
		logic [23:0] cipher_q[$];
		logic [15:0] sum;
		logic [7:0]  parity;
		logic [7:0]  b;
		logic        stopped;
		logic        with_zeros;
		int          groups;
		int          counted;
		int          n;
		msg_q.delete();
		if (kind == MSG_NOISE) begin
			n = $urandom_range(1, 12);
			repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
			msg_q.push_back(8'h00);
			return;
		end
		groups = ($urandom_range(0, 11) == 0) ? $urandom_range(22, 24) : $urandom_range(0, 5);
		with_zeros = ($urandom_range(0, 2) == 0);
		salt = 24'($urandom);
		salt_mask = gen_step({8'd0, salt}, cur_lic);
		mask = cur_lic ? gen_step(salt_mask, 1'b1) : salt_mask;
		key = {8'd0, cur_key};
		sum = '0;
		parity = '0;
		stopped = 1'b0;
		counted = 0;
		repeat (groups) begin
			key = gen_step(key, cur_lic);
			mask = cur_lic ? gen_step(rotl32(mask, key[4:0]), 1'b1)
				: rotl32(mask, {1'b0, key[3:0]});
			key = gen_step(key, cur_lic);
			for (int i = 0; i < 3; i++) begin
				b = (with_zeros && $urandom_range(0, 7) == 0) ? 8'h00
					: 8'($urandom_range(0, 255));
				plain[8*i +: 8] = b;
				if (!stopped) begin
					if (b == 8'h00 || counted >= CHECK_LIMIT) begin
						stopped = 1'b1;
					end else begin
						sum = sum + {8'd0, b};
						parity = parity ^ b;
						counted++;
					end
				end
			end
			cipher_q.push_back(rotl24(plain, key[4:0]) ^ mask[23:0]);
		end
		check = {sum, parity};
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(0, 23);
			check[n] = ~check[n];
		end
		encode_word(salt);
		encode_word(check ^ salt_mask[23:0]);
		foreach (cipher_q[g])
			encode_word(cipher_q[g]);
		msg_q.push_back(8'h00);
		if (kind == MSG_BAD_CHAR) begin
			// keep the closing NUL so the skip ends with this message
			n = $urandom_range(0, msg_q.size() - 2);
			msg_q[n] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h01, 8'h2F))
				: 8'($urandom_range(8'h7B, 8'hFF));
		end else if (kind == MSG_CUT) begin
			n = $urandom_range(0, msg_q.size() - 1);
			while (msg_q.size() > n)
				void'(msg_q.pop_back());
			msg_q.push_back(8'h00);
		end
	endtask

	initial begin
		int        setting;
		int        pick;
		msg_kind_t kind;
		key_plan = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000};
		key_plan[2] = 24'($urandom);
		key_plan[3] = 24'($urandom);
		key_plan[5] = 24'($urandom);
		variant_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_setting(24'h000000, 1'b0);
		foreach (directed_syms[k])
			send_symbol(directed_syms[k]);
		setting = 0;
		while (sent < SYMBOL_TARGET) begin
			if (setting < PLAN_LEN && sent >= (setting + 1) * SETTING_SPAN) begin
				apply_setting(key_plan[setting], variant_plan[setting]);
				setting++;
			end
			pick = $urandom_range(0, 9);
			if (pick < 6)
				kind = MSG_CLEAN;
			else if (pick == 6)
				kind = MSG_BAD_CHAR;
			else if (pick == 7)
				kind = MSG_CUT;
			else
				kind = MSG_NOISE;
			build_message(kind);
			foreach (msg_q[k])
				send_symbol(msg_q[k]);
		end
		settle();
		if (mismatches == 0 && pending == 0)
			$display("[salted_string_decryptor] OK");
		else
			$display("[salted_string_decryptor] ERROR");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_gen.sv
hw/rtl/salted_string_decryptor.sv
test/ssd_checker.sv
test/tb_salted_string_decryptor.sv
